FILE: rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types, constants and calendar helpers for the NTP-to-calendar block.
// ----------------------------------------------------------------------------
package ntc_pkg;

    localparam int unsigned NTP_W     = 32;
    localparam int unsigned ZONE_W    = 5;
    localparam int unsigned OUT_W     = 40;

    // Adding the era-1 rollover (2085978496) and subtracting the 1900-to-1970
    // offset are the same operation modulo 2^32.
    localparam logic [31:0] NTP_TO_UNIX   = 32'd2208988800;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;

    // multiplier operands for the remainder steps
    localparam logic [25:0] K_DAY_SECS  = 26'd86400;
    localparam logic [25:0] K_HOUR_SECS = 26'd3600;
    localparam logic [25:0] K_MIN_SECS  = 26'd60;
    localparam logic [25:0] K_WEEK_DAYS = 26'd7;

    // reciprocals: floor(x * RCP >> SH) is exact over the operand range
    // days: (t >> 7) / 675, 25-bit operand
    localparam logic [25:0] RCP_DAY     = 26'd50903317;
    localparam int unsigned RCP_DAY_SH  = 35;
    // hours: (sod >> 4) / 225, 13-bit operand
    localparam logic [25:0] RCP_HOUR    = 26'd9321;
    localparam int unsigned RCP_HOUR_SH = 21;
    // minutes: (rem >> 2) / 15, 10-bit operand
    localparam logic [25:0] RCP_MIN     = 26'd1093;
    localparam int unsigned RCP_MIN_SH  = 14;
    // weeks: days / 7, 16-bit operand
    localparam logic [25:0] RCP_WEEK    = 26'd74899;
    localparam int unsigned RCP_WEEK_SH = 19;

    // 1970-01-01 was a Thursday: weekday = (days mod 7 + 4) mod 7
    localparam logic [2:0] WDAY_EPOCH = 3'd4;
    localparam logic [2:0] WDAY_WRAP  = 3'd3;

    // year index counts from 1970; 2100 is the only non-leap century year in range
    localparam logic [7:0] YEAR_IDX_2100 = 8'd130;
    localparam logic [7:0] YEAR_2000_ADJ = 8'd226; // -30 mod 256
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EPOCH,
        ST_ZONE,
        ST_DAY_Q,
        ST_DAY_P,
        ST_DAY_R,
        ST_HOUR_Q,
        ST_HOUR_P,
        ST_HOUR_R,
        ST_MIN_Q,
        ST_MIN_P,
        ST_MIN_R,
        ST_WDAY_Q,
        ST_WDAY_P,
        ST_WDAY_R,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [4:0] day_of_month;
        logic [3:0] month;
        logic [7:0] year_from_2000;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_result;

    function automatic logic is_leap_idx(input logic [7:0] k);
        return (k[1:0] == 2'd2) && (k != YEAR_IDX_2100);
    endfunction

    // m is the month index 0..11
    function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] m);
        logic [3:0] mm;
        mm = (m > 4'd6) ? (m - 4'd1) : m;
        if (m == 4'd1) begin
            return leap ? 5'd29 : 5'd28;
        end
        return mm[0] ? 5'd30 : 5'd31;
    endfunction

endpackage

FILE: rtl/ntp_timestamp_to_calendar_top.sv
// Sequence: epoch and zone adjust, reciprocal divides for days, hours, minutes and
//   weekday, year stepping from 1970, month stepping, then the output register.
// Flow: one timestamp at a time; the next input beat can be taken in the cycle after
//   the core hands off its result, and output stalls can hold off that handoff.
// Reset: synchronous, active low; clears the sequencer, output valid and zone.
// ----------------------------------------------------------------------------
// ntp_timestamp_to_calendar_top
// NTP transmit seconds to calendar date and time in a configured zone.
// ----------------------------------------------------------------------------
module ntp_timestamp_to_calendar_top
    import ntc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ZONE_W-1:0] i_cfg_wdata,    // zone_offset_hours, signed
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [NTP_W-1:0]  s_axis_tdata,   // ntp_seconds
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // second[5:0], minute[11:6], hour[16:12], weekday[19:17],
    // year_from_2000[27:20], month[31:28], day_of_month[36:32], zero pad
    output logic [OUT_W-1:0]  m_axis_tdata
);

    logic [ZONE_W-1:0] r_zone;
    logic              r_out_valid;
    t_result           r_out;
    logic              res_valid;
    logic              res_ready;
    t_result           res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= '0;
        end else if (i_cfg_we) begin
            r_zone <= i_cfg_wdata;
        end
    end

    ntc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_zone      (r_zone),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register frees the core while a beat waits downstream
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W - $bits(t_result)){1'b0}}, r_out};

endmodule

FILE: rtl/ntc_sub.sv
// ----------------------------------------------------------------------------
// ntc_sub
// Shared 32-bit subtract and compare unit.
// ----------------------------------------------------------------------------
module ntc_sub
    import ntc_pkg::*;
(
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_ge
);

    logic [32:0] diff_ext;

    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[31:0];
    assign o_ge     = ~diff_ext[32];

endmodule

FILE: rtl/ntc_core.sv
// ----------------------------------------------------------------------------
// ntc_core
// Sequencer and datapath: epoch and zone adjust, reciprocal divides on one
// shared multiplier, then year and month stepping on one subtract/compare unit.
// ----------------------------------------------------------------------------
module ntc_core
    import ntc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ZONE_W-1:0] i_zone,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [NTP_W-1:0]  i_in_data,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res
);

    t_state r_state, n_state;

    logic [31:0] r_q, n_q;         // working value: seconds, then remainders
    logic [31:0] r_p, n_p;         // registered product or quotient
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [2:0]  r_wday, n_wday;
    logic [7:0]  r_yidx, n_yidx;
    logic [3:0]  r_mon, n_mon;

    logic [31:0] alu_a, alu_b, alu_diff;
    logic        alu_ge;

    logic [25:0] mul_a, mul_b;
    logic [51:0] mul_p;

    logic [31:0] zone_prod;
    logic        leap;
    logic [4:0]  mdays;
    logic [2:0]  wday_rem;

    ntc_sub u_sub (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_ge   (alu_ge)
    );

    // 26 x 26 unsigned
    assign mul_p     = {26'd0, mul_a} * {26'd0, mul_b};
    assign zone_prod = {{(32-ZONE_W){i_zone[ZONE_W-1]}}, i_zone} * SECS_PER_HOUR;
    assign leap      = is_leap_idx(r_yidx);
    assign mdays     = days_in_month(leap, r_mon);
    assign wday_rem  = alu_diff[2:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_EPOCH;
            ST_EPOCH:  n_state = ST_ZONE;
            ST_ZONE:   n_state = ST_DAY_Q;
            ST_DAY_Q:  n_state = ST_DAY_P;
            ST_DAY_P:  n_state = ST_DAY_R;
            ST_DAY_R:  n_state = ST_HOUR_Q;
            ST_HOUR_Q: n_state = ST_HOUR_P;
            ST_HOUR_P: n_state = ST_HOUR_R;
            ST_HOUR_R: n_state = ST_MIN_Q;
            ST_MIN_Q:  n_state = ST_MIN_P;
            ST_MIN_P:  n_state = ST_MIN_R;
            ST_MIN_R:  n_state = ST_WDAY_Q;
            ST_WDAY_Q: n_state = ST_WDAY_P;
            ST_WDAY_P: n_state = ST_WDAY_R;
            ST_WDAY_R: n_state = ST_YEAR;
            ST_YEAR:   if (!alu_ge) n_state = ST_MONTH;
            ST_MONTH: begin
                if (r_mon == LAST_MONTH_IDX || !alu_ge) n_state = ST_DONE;
            end
            ST_DONE:   if (i_res_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // unit operands and datapath updates
    always_comb begin
        alu_a  = r_q;
        alu_b  = 32'd0;
        mul_a  = 26'd0;
        mul_b  = 26'd0;
        n_q    = r_q;
        n_p    = r_p;
        n_days = r_days;
        n_hour = r_hour;
        n_min  = r_min;
        n_sec  = r_sec;
        n_wday = r_wday;
        n_yidx = r_yidx;
        n_mon  = r_mon;
        case (r_state)
            ST_IDLE: begin
                n_q = i_in_data;
            end
            ST_EPOCH: begin
                alu_b = NTP_TO_UNIX;
                n_q   = alu_diff;
            end
            ST_ZONE: begin
                alu_b = zone_prod;
                n_q   = alu_diff;
            end
            ST_DAY_Q: begin
                mul_a  = {1'b0, r_q[31:7]};
                mul_b  = RCP_DAY;
                n_days = mul_p[RCP_DAY_SH +: 16];
            end
            ST_DAY_P: begin
                mul_a = {10'd0, r_days};
                mul_b = K_DAY_SECS;
                n_p   = mul_p[31:0];
            end
            ST_DAY_R: begin
                alu_b = r_p;
                n_q   = alu_diff;      // seconds of the day
            end
            ST_HOUR_Q: begin
                mul_a  = {13'd0, r_q[16:4]};
                mul_b  = RCP_HOUR;
                n_hour = mul_p[RCP_HOUR_SH +: 5];
            end
            ST_HOUR_P: begin
                mul_a = {21'd0, r_hour};
                mul_b = K_HOUR_SECS;
                n_p   = mul_p[31:0];
            end
            ST_HOUR_R: begin
                alu_b = r_p;
                n_q   = alu_diff;      // seconds of the hour
            end
            ST_MIN_Q: begin
                mul_a = {16'd0, r_q[11:2]};
                mul_b = RCP_MIN;
                n_min = mul_p[RCP_MIN_SH +: 6];
            end
            ST_MIN_P: begin
                mul_a = {20'd0, r_min};
                mul_b = K_MIN_SECS;
                n_p   = mul_p[31:0];
            end
            ST_MIN_R: begin
                alu_b = r_p;
                n_sec = alu_diff[5:0];
            end
            ST_WDAY_Q: begin
                mul_a = {10'd0, r_days};
                mul_b = RCP_WEEK;
                n_p   = {19'd0, mul_p[RCP_WEEK_SH +: 13]};
            end
            ST_WDAY_P: begin
                mul_a = r_p[25:0];
                mul_b = K_WEEK_DAYS;
                n_p   = mul_p[31:0];
            end
            ST_WDAY_R: begin
                alu_a  = {16'd0, r_days};
                alu_b  = r_p;
                n_wday = (wday_rem >= WDAY_WRAP) ? (wday_rem - WDAY_WRAP)
                                                 : (wday_rem + WDAY_EPOCH);
                n_yidx = 8'd0;
            end
            ST_YEAR: begin
                alu_a = {16'd0, r_days};
                alu_b = leap ? 32'd366 : 32'd365;
                if (alu_ge) begin
                    n_days = alu_diff[15:0];
                    n_yidx = r_yidx + 8'd1;
                end else begin
                    n_mon = 4'd0;
                end
            end
            ST_MONTH: begin
                alu_a = {16'd0, r_days};
                alu_b = {27'd0, mdays};
                if (r_mon != LAST_MONTH_IDX && alu_ge) begin
                    n_days = alu_diff[15:0];
                    n_mon  = r_mon + 4'd1;
                end
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_q    <= n_q;
        r_p    <= n_p;
        r_days <= n_days;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_sec  <= n_sec;
        r_wday <= n_wday;
        r_yidx <= n_yidx;
        r_mon  <= n_mon;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);

    always_comb begin
        o_res.second         = r_sec;
        o_res.minute         = r_min;
        o_res.hour           = r_hour;
        o_res.weekday        = r_wday;
        o_res.year_from_2000 = r_yidx + YEAR_2000_ADJ;
        o_res.month          = r_mon + 4'd1;
        o_res.day_of_month   = r_days[4:0] + 5'd1;
    end

endmodule

FILE: verif/ntp_calendar_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntp_calendar_checker
// Watches the zone register port and both stream channels of the NTP-to-
// calendar block. It predicts each converted date and time from the accepted
// timestamp and compares every field of the outgoing beats in order.
// ----------------------------------------------------------------------------
module ntp_calendar_checker
    import ntc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ZONE_W-1:0] i_cfg_wdata,
    input  logic              i_ts_valid,
    input  logic              i_ts_ready,
    input  logic [NTP_W-1:0]  i_ts_data,
    input  logic              i_cal_valid,
    input  logic              i_cal_ready,
    input  logic [OUT_W-1:0]  i_cal_data,
    output int unsigned       o_pending,
    output int unsigned       o_fail_count
);

    localparam logic [31:0] ERA1_ROLLOVER = 32'd2085978496;
    localparam logic [31:0] NTP_TO_1970   = 32'd2208988800;
    localparam logic [31:0] DAY_SECS      = 32'd86400;

    logic [ZONE_W-1:0] zone_hours = '0;
    int unsigned       n_accepted = 0;
    int unsigned       n_returned = 0;
    int unsigned       fail_total = 0;
    t_result           calendar_q[$];

    assign o_pending    = n_accepted - n_returned;
    assign o_fail_count = fail_total;

    function automatic bit leap_year(input logic [31:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // m counts months from 0
    function automatic logic [31:0] month_days(input bit leap, input logic [31:0] m);
        logic [31:0] k;
        if (m == 1) begin
            return leap ? 32'd29 : 32'd28;
        end
        k = (m > 6) ? m - 1 : m;
        return k[0] ? 32'd30 : 32'd31;
    endfunction

    function automatic t_result calendar_of(input logic [31:0] ntp,
                                            input logic [ZONE_W-1:0] zone);
        logic [31:0] unix;
        logic [31:0] offs;
        logic [31:0] sod;
        logic [31:0] days;
        logic [31:0] yr;
        logic [31:0] ylen;
        logic [31:0] mon;
        bit          leap;
        t_result     r;
        unix = ntp[31] ? ntp + ERA1_ROLLOVER : ntp - NTP_TO_1970;
        offs = {{(32 - ZONE_W){zone[ZONE_W-1]}}, zone};
        unix = unix - offs * 32'd3600;   // wraps mod 2^32
        sod  = unix % DAY_SECS;
        days = unix / DAY_SECS;
        r.second  = 6'(sod % 60);
        r.minute  = 6'((sod % 3600) / 60);
        r.hour    = 5'(sod / 3600);
        r.weekday = 3'((days + 4) % 7);   // the epoch day was a Thursday
        yr = 32'd1970;
        ylen = leap_year(yr) ? 32'd366 : 32'd365;
        while (days >= ylen) begin
            days = days - ylen;
            yr = yr + 1;
            ylen = leap_year(yr) ? 32'd366 : 32'd365;
        end
        r.year_from_2000 = 8'(yr - 32'd2000);
        leap = leap_year(yr);
        mon = 0;
        while (mon < 11 && days >= month_days(leap, mon)) begin
            days = days - month_days(leap, mon);
            mon = mon + 1;
        end
        r.month        = 4'(mon + 1);
        r.day_of_month = 5'(days + 1);
        return r;
    endfunction

    function automatic int unsigned field_diff(input string name, input int want,
                                               input int got, input bit loud);
        if (want == got) begin
            return 0;
        end
        if (loud) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_result     want;
        t_result     got;
        int unsigned errs;
        bit          loud;
        errs = 0;
        loud = (fail_total < 40);
        if (!i_rst_n) begin
            zone_hours <= '0;
        end else begin
            if (i_cfg_we) begin
                zone_hours <= i_cfg_wdata;
            end
            if (i_ts_valid && i_ts_ready) begin
                calendar_q.push_back(calendar_of(i_ts_data, zone_hours));
                n_accepted <= n_accepted + 1;
            end
            if (i_cal_valid && i_cal_ready) begin
                n_returned <= n_returned + 1;
                got = i_cal_data[$bits(t_result)-1:0];
                if (calendar_q.size() == 0) begin
                    errs = 1;
                    if (loud) begin
                        $display("%0t: result beat with nothing outstanding, got %h",
                                 $time, i_cal_data);
                    end
                end else begin
                    want = calendar_q.pop_front();
                    errs += field_diff("second", want.second, got.second, loud);
                    errs += field_diff("minute", want.minute, got.minute, loud);
                    errs += field_diff("hour", want.hour, got.hour, loud);
                    errs += field_diff("weekday", want.weekday, got.weekday, loud);
                    errs += field_diff("year_from_2000", $signed(want.year_from_2000),
                                       $signed(got.year_from_2000), loud);
                    errs += field_diff("month", want.month, got.month, loud);
                    errs += field_diff("day_of_month", want.day_of_month,
                                       got.day_of_month, loud);
                    errs += field_diff("pad", 0,
                                       int'(i_cal_data[OUT_W-1:$bits(t_result)]), loud);
                end
            end
            if (errs != 0) begin
                fail_total <= fail_total + errs;
            end
        end
    end

endmodule

FILE: verif/ntp_timestamp_to_calendar_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ntp_timestamp_to_calendar_top_test
// Drives NTP timestamps through the calendar block under a range of zone
// offsets, with random gaps on input and random back-pressure on output.
// Corner timestamps come first, then random ones biased toward the epoch,
// era and leap-year boundaries. The checker scores every result beat.
// ----------------------------------------------------------------------------
module ntp_timestamp_to_calendar_top_test
    import ntc_pkg::*;
();

    localparam logic [31:0] NTP_UNIX_EPOCH = 32'd2208988800;
    localparam logic [31:0] NTP_2100_FEB28 = 32'd2021477504;
    localparam int          ITEMS_PER_ZONE = 155;
    localparam int          TAIL_CYCLES    = 300;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [ZONE_W-1:0] i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [NTP_W-1:0]  s_axis_tdata = '0;   // ntp_seconds
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // second, minute, hour, weekday, year_from_2000, month, day_of_month, pad
    logic [OUT_W-1:0]  m_axis_tdata;

    int unsigned pending;
    int unsigned fail_count;
    int unsigned n_sent = 0;
    bit          quiet_run = 1'b0;
    bit          steady_sink = 1'b0;

    // both eras, the 2036 and 2106 wraps, leap days and year ends
    logic [31:0] corner_ts [10] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        NTP_UNIX_EPOCH, NTP_UNIX_EPOCH - 32'd1,
        32'd3160771200,                 // 2000-02-29
        32'd3944678399,                 // 2024-12-31 23:59:59
        NTP_2100_FEB28,                 // 2100 is not a leap year
        NTP_2100_FEB28 + 32'd86400
    };

    // includes both extremes of the 5-bit register; ends back at zero
    int zone_plan [8] = '{-12, 14, -16, 15, -1, 1, 6, 0};

    ntp_timestamp_to_calendar_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ntp_calendar_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_ts_valid   (s_axis_tvalid),
        .i_ts_ready   (s_axis_tready),
        .i_ts_data    (s_axis_tdata),
        .i_cal_valid  (m_axis_tvalid),
        .i_cal_ready  (m_axis_tready),
        .i_cal_data   (m_axis_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_timestamp(input logic [31:0] ts);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) begin
            quiet_run = !quiet_run;
        end
        gap = quiet_run ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ts;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_sent++;
    endtask

    // drop valid and let the checker count the last accepted beat before polling pending
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // result sink: random stall before each beat, with stretches of none
    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 49) == 0) begin
                steady_sink = !steady_sink;
            end
            stall = steady_sink ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    initial begin
        logic [31:0] ts;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zone offset still at its reset value here
        foreach (corner_ts[k]) begin
            send_timestamp(corner_ts[k]);
        end
        wait_drain();

        foreach (zone_plan[p]) begin
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= ZONE_W'(zone_plan[p]);
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;
            // the zone step wraps across the 1970 / 2106 boundary here
            send_timestamp(NTP_UNIX_EPOCH);
            send_timestamp(NTP_UNIX_EPOCH - 32'd1);
            for (int n = 0; n < ITEMS_PER_ZONE; n++) begin
                case ($urandom_range(0, 9))
                    0, 1: ts = NTP_UNIX_EPOCH + 32'($urandom_range(0, 200000)) - 32'd100000;
                    2:    ts = 32'h8000_0000 + 32'($urandom_range(0, 200000)) - 32'd100000;
                    3:    ts = 32'($urandom_range(0, 200000)) - 32'd100000;
                    4:    ts = NTP_2100_FEB28 + 32'($urandom_range(0, 8000000)) - 32'd4000000;
                    default: ts = $urandom();
                endcase
                send_timestamp(ts);
                if ($urandom_range(0, 63) == 0) begin
                    wait_drain();
                end
            end
            wait_drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d timestamps converted under the reset zone and %0d written offsets",
                 n_sent, $size(zone_plan));
        $display("offsets -16 and 15 included; %0d field errors or stray beats", fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
